FILE: src/assert_macros.svh
// Assertion helpers for the RTL. Every check samples on clk and is
// switched off while arst_n is low, so a user must have both in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true at a clock edge.
`define CHK_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

// When pre holds at an edge, post must hold at the following edge.
`define CHK_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("expected follow-up did not occur");

`endif

FILE: src/bsm_pkg.sv
package bsm_pkg;

	// Item kinds on the request channel; code 3 is unused and does nothing.
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// Instruction opcodes (high nibble of the first instruction byte).
	localparam logic [3:0] OPC_LOAD_MEM = 4'h1;
	localparam logic [3:0] OPC_LOAD_IMM = 4'h2;
	localparam logic [3:0] OPC_STORE    = 4'h3;
	localparam logic [3:0] OPC_MOVE     = 4'h4;
	localparam logic [3:0] OPC_ADD      = 4'h5;
	localparam logic [3:0] OPC_FADD     = 4'h6;
	localparam logic [3:0] OPC_OR       = 4'h7;
	localparam logic [3:0] OPC_AND      = 4'h8;
	localparam logic [3:0] OPC_XOR      = 4'h9;
	localparam logic [3:0] OPC_ROT      = 4'hA;
	localparam logic [3:0] OPC_JUMP     = 4'hB;
	localparam logic [3:0] OPC_HALT     = 4'hC;

	// The conditional jump compares against this register.
	localparam logic [3:0] REG_R0 = 4'd0;

	typedef struct packed {
		logic [3:0] opcode;
		logic [3:0] field_r;
		logic [3:0] field_s;
		logic [3:0] field_t;
		logic [7:0] next_pc;
		logic       stopped;
		logic       wrote_register;
		logic       wrote_memory;
		logic [7:0] target;
		logic [7:0] value;
	} rsp_t;

	// 8-bit float: sign bit 7, exponent 6..4, mantissa 3..0. The operand with
	// the smaller exponent has its mantissa aligned right; the larger exponent
	// is kept. A mantissa carry renormalizes, saturating at the top exponent.
	function automatic logic [7:0] fadd(input logic [7:0] a, input logic [7:0] b);
		logic       sa;
		logic       sb;
		logic       s;
		logic [2:0] ea;
		logic [2:0] eb;
		logic [2:0] e;
		logic [3:0] ma;
		logic [3:0] mb;
		logic [4:0] m;
		sa = a[7];
		sb = b[7];
		ea = a[6:4];
		eb = b[6:4];
		ma = a[3:0];
		mb = b[3:0];
		if (ea > eb) begin
			mb = mb >> (ea - eb);
			e  = ea;
		end else begin
			ma = ma >> (eb - ea);
			e  = eb;
		end
		if (sa == sb) begin
			s = sa;
			m = {1'b0, ma} + {1'b0, mb};
			if (m[4]) begin
				if (e == 3'd7) begin
					m = 5'd15;
				end else begin
					m = m >> 1;
					e = e + 3'd1;
				end
			end
		end else if (ma > mb) begin
			s = sa;
			m = {1'b0, ma - mb};
		end else if (mb > ma) begin
			s = sb;
			m = {1'b0, mb - ma};
		end else begin
			s = 1'b0;
			m = 5'd0;
		end
		return {s, e, m[3:0]};
	endfunction

	// Rotate right by n places.
	function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
		logic [15:0] both;
		both = {v, v} >> n;
		return both[7:0];
	endfunction

endpackage

FILE: src/bsm_req_if.sv
interface bsm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] mem_addr;
	logic [7:0] mem_data;

	modport source (output valid, output op, output mem_addr, output mem_data, input ready);
	modport sink (input valid, input op, input mem_addr, input mem_data, output ready);
endinterface

FILE: src/bsm_rsp_if.sv
interface bsm_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] opcode;
	logic [3:0] field_r;
	logic [3:0] field_s;
	logic [3:0] field_t;
	logic [7:0] next_pc;
	logic       stopped;
	logic       wrote_register;
	logic       wrote_memory;
	logic [7:0] target;
	logic [7:0] value;

	modport source (
		output valid, output opcode, output field_r, output field_s, output field_t,
		output next_pc, output stopped, output wrote_register, output wrote_memory,
		output target, output value, input ready
	);
	modport sink (
		input valid, input opcode, input field_r, input field_s, input field_t,
		input next_pc, input stopped, input wrote_register, input wrote_memory,
		input target, input value, output ready
	);
endinterface

FILE: src/bsm_ram.sv
module bsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered and holds while its port is not enabled.
	// A read of the entry being written returns the new data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
		end
	end

endmodule

FILE: src/bsm_zram.sv
module bsm_zram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [DEPTH-1:0] written_q;
	logic             hit_a_q;
	logic             hit_b_q;
	logic [WIDTH-1:0] ram_a;
	logic [WIDTH-1:0] ram_b;

	bsm_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re_a   (re_a),
		.raddr_a(raddr_a),
		.rdata_a(ram_a),
		.re_b   (re_b),
		.raddr_b(raddr_b),
		.rdata_b(ram_b)
	);

	// One flag per entry marks it written since reset; unwritten entries read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_a_q   <= 1'b0;
			hit_b_q   <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re_a) begin
				hit_a_q <= written_q[raddr_a] || (we && waddr == raddr_a);
			end
			if (re_b) begin
				hit_b_q <= written_q[raddr_b] || (we && waddr == raddr_b);
			end
		end
	end

	assign rdata_a = hit_a_q ? ram_a : '0;
	assign rdata_b = hit_b_q ? ram_b : '0;

endmodule

FILE: src/brookshear_machine_step_unit.sv
// Step unit for the 8-bit two-byte-instruction teaching machine.
// The req channel carries items: a memory byte write, one instruction step,
// or a memory byte read. Every accepted item yields exactly one result on
// the rsp channel, in order; a transfer happens when valid and ready are high.
// Main memory (256 bytes) and the 16-entry register file sit in synchronous
// RAMs with registered read data; a stage sequence fetches, decodes and
// executes, and all writes land in the execute stage.
// A request passes from decode to the execute stage, and its result is registered in
// the output register, from which it leaves on rsp. Throughput: one item every two
// cycles, set by the fetch of the next instruction, which must wait for the
// execute stage of the previous one to settle the program counter.
// Reset clears the program counter, empties every stage and marks all memory
// and register entries unwritten, so they read as zero at once; no clearing
// pass is needed and req.ready may rise right after reset.
// When the receiver stalls, the result waits in the output register; one more
// item can still be taken and runs up to the execute stage, where it holds
// until the output register frees, and req.ready stays low meanwhile.
`include "assert_macros.svh"

module brookshear_machine_step_unit (
	input logic       clk,
	input logic       arst_n,
	bsm_req_if.sink   req,
	bsm_rsp_if.source rsp
);
	import bsm_pkg::*;

	// Handshake and stage control.
	logic accept;
	logic out_free;
	logic s1_go;
	logic s2_go;

	// Control registers.
	logic       valid_s1;
	logic       valid_s2;
	logic       out_valid_q;
	logic [7:0] pc_q;

	// Stage payloads.
	op_t        op_s1;
	logic [7:0] addr_s1;
	logic [7:0] data_s1;
	logic [7:0] pc_s1;
	op_t        op_s2;
	logic [7:0] addr_s2;
	logic [7:0] data_s2;
	logic [7:0] pc_s2;
	logic [7:0] b0_s2;
	logic [7:0] b1_s2;
	rsp_t       rsp_q;

	// Main memory ports.
	logic       mem_we;
	logic [7:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic       mem_re_a;
	logic [7:0] mem_raddr_a;
	logic [7:0] mem_rd_a;
	logic       mem_re_b;
	logic [7:0] mem_raddr_b;
	logic [7:0] mem_rd_b;

	// Register file ports.
	logic       reg_we;
	logic [3:0] reg_waddr;
	logic [7:0] reg_wdata;
	logic [3:0] reg_raddr_a;
	logic [7:0] reg_rd_a;
	logic [3:0] reg_raddr_b;
	logic [7:0] reg_rd_b;

	// Decode and execute.
	logic [3:0] opc_s1;
	logic [7:0] pc_eff;
	logic [3:0] opc;
	logic [3:0] fr;
	logic [3:0] fs;
	logic [3:0] ft;
	logic       wreg;
	logic       wmem;
	logic [7:0] pc_next;
	rsp_t       res;

	// The output register frees when empty or when its result transfers this
	// cycle. The execute stage only runs into a free output register, and a new
	// request is taken only when nothing sits in decode and execute is not
	// stalled, so no pending RAM read data is ever overwritten.
	assign out_free  = !out_valid_q || rsp.ready;
	assign s2_go     = valid_s2 && out_free;
	assign s1_go     = valid_s1 && (!valid_s2 || s2_go);
	assign req.ready = !valid_s1 && (!valid_s2 || out_free);
	assign accept    = req.valid && req.ready;

	// The program counter seen by a new request includes the outcome of the
	// step that is executing in the same cycle (jump, halt or plain advance).
	assign pc_eff = s2_go ? pc_next : pc_q;

	// Fetch: port A reads the first instruction byte (or the byte of a read
	// request) and port B the second byte, wrapping at the top of memory.
	// In decode, port A is reused to read the direct-load operand at XY.
	assign opc_s1   = mem_rd_a[7:4];
	assign mem_re_a = accept || s1_go;
	assign mem_re_b = accept;
	assign mem_raddr_b = pc_eff + 8'd1;

	always_comb begin
		if (accept) begin
			mem_raddr_a = (op_t'(req.op) == OP_STEP) ? pc_eff : req.mem_addr;
		end else begin
			mem_raddr_a = mem_rd_b;
		end
	end

	// Decode picks the register operands: store, rotate and jump read R[r]
	// (jump also reads R0); move reads R[s], and the ALU forms read R[s] and R[t].
	always_comb begin
		if (opc_s1 inside {OPC_STORE, OPC_ROT, OPC_JUMP}) begin
			reg_raddr_a = mem_rd_a[3:0];
		end else begin
			reg_raddr_a = mem_rd_b[7:4];
		end
		if (opc_s1 == OPC_JUMP) begin
			reg_raddr_b = REG_R0;
		end else begin
			reg_raddr_b = mem_rd_b[3:0];
		end
	end

	bsm_zram #(
		.WIDTH(8),
		.DEPTH(256)
	) u_main_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re_a   (mem_re_a),
		.raddr_a(mem_raddr_a),
		.rdata_a(mem_rd_a),
		.re_b   (mem_re_b),
		.raddr_b(mem_raddr_b),
		.rdata_b(mem_rd_b)
	);

	bsm_zram #(
		.WIDTH(8),
		.DEPTH(16)
	) u_reg_file (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (reg_we),
		.waddr  (reg_waddr),
		.wdata  (reg_wdata),
		.re_a   (s1_go),
		.raddr_a(reg_raddr_a),
		.rdata_a(reg_rd_a),
		.re_b   (s1_go),
		.raddr_b(reg_raddr_b),
		.rdata_b(reg_rd_b)
	);

	// Execute: operands come straight from the RAM read registers. Writes to
	// memory or registers happen only in the cycle the result is registered.
	assign opc = b0_s2[7:4];
	assign fr  = b0_s2[3:0];
	assign fs  = b1_s2[7:4];
	assign ft  = b1_s2[3:0];

	always_comb begin
		wreg      = 1'b0;
		wmem      = 1'b0;
		reg_waddr = fr;
		reg_wdata = '0;
		mem_waddr = addr_s2;
		mem_wdata = data_s2;
		pc_next   = pc_s2;
		res       = '0;
		case (op_s2)
			OP_WRITE: begin
				wmem = 1'b1;
			end
			OP_READ: begin
			end
			OP_STEP: begin
				pc_next = pc_s2 + 8'd2;
				case (opc)
					OPC_LOAD_MEM: begin
						wreg      = 1'b1;
						reg_wdata = mem_rd_a;
					end
					OPC_LOAD_IMM: begin
						wreg      = 1'b1;
						reg_wdata = b1_s2;
					end
					OPC_STORE: begin
						wmem      = 1'b1;
						mem_waddr = b1_s2;
						mem_wdata = reg_rd_a;
					end
					OPC_MOVE: begin
						wreg      = 1'b1;
						reg_waddr = ft;
						reg_wdata = reg_rd_a;
					end
					OPC_ADD: begin
						wreg      = 1'b1;
						reg_wdata = reg_rd_a + reg_rd_b;
					end
					OPC_FADD: begin
						wreg      = 1'b1;
						reg_wdata = fadd(reg_rd_a, reg_rd_b);
					end
					OPC_OR: begin
						wreg      = 1'b1;
						reg_wdata = reg_rd_a | reg_rd_b;
					end
					OPC_AND: begin
						wreg      = 1'b1;
						reg_wdata = reg_rd_a & reg_rd_b;
					end
					OPC_XOR: begin
						wreg      = 1'b1;
						reg_wdata = reg_rd_a ^ reg_rd_b;
					end
					OPC_ROT: begin
						wreg      = 1'b1;
						reg_wdata = rotr8(reg_rd_a, ft[2:0]);
					end
					OPC_JUMP: begin
						if (reg_rd_a == reg_rd_b) begin
							pc_next = b1_s2;
						end
					end
					OPC_HALT: begin
						pc_next = '0;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		res.next_pc        = pc_next;
		res.wrote_register = wreg;
		res.wrote_memory   = wmem;
		if (op_s2 == OP_STEP) begin
			res.opcode  = opc;
			res.field_r = fr;
			res.field_s = fs;
			res.field_t = ft;
			res.stopped = (pc_next == 8'd0);
		end
		if (wreg) begin
			res.target = {4'd0, reg_waddr};
			res.value  = reg_wdata;
		end else if (wmem) begin
			res.target = mem_waddr;
			res.value  = mem_wdata;
		end else if (op_s2 == OP_READ) begin
			res.target = addr_s2;
			res.value  = b0_s2;
		end
	end

	assign reg_we = wreg && s2_go;
	assign mem_we = wmem && s2_go;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (s2_go) begin
				out_valid_q <= 1'b1;
				pc_q        <= pc_next;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(req.op);
			addr_s1 <= req.mem_addr;
			data_s1 <= req.mem_data;
			pc_s1   <= pc_eff;
		end
		if (s1_go) begin
			op_s2   <= op_s1;
			addr_s2 <= addr_s1;
			data_s2 <= data_s1;
			pc_s2   <= pc_s1;
			b0_s2   <= mem_rd_a;
			b1_s2   <= mem_rd_b;
		end
		if (s2_go) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.opcode         = rsp_q.opcode;
	assign rsp.field_r        = rsp_q.field_r;
	assign rsp.field_s        = rsp_q.field_s;
	assign rsp.field_t        = rsp_q.field_t;
	assign rsp.next_pc        = rsp_q.next_pc;
	assign rsp.stopped        = rsp_q.stopped;
	assign rsp.wrote_register = rsp_q.wrote_register;
	assign rsp.wrote_memory   = rsp_q.wrote_memory;
	assign rsp.target         = rsp_q.target;
	assign rsp.value          = rsp_q.value;

	// An instruction writes memory or a register, never both.
	`CHK_NEVER(a_single_write, mem_we && reg_we)
	// A taken request occupies decode, which blocks the next request.
	`CHK_NEXT(a_accept_blocks, accept, valid_s1 && !req.ready)
	// A stalled execute stage keeps its instruction untouched.
	`CHK_NEXT(a_exec_holds, valid_s2 && !out_free, valid_s2 && $stable(b0_s2) && $stable(b1_s2))
	// The program counter moves only when a step executes.
	`CHK_NEXT(a_pc_on_step, !(s2_go && op_s2 == OP_STEP), $stable(pc_q))

endmodule
